@@ sv/pcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcw_pkg: shared types and widths for the wire crossing test
// Coordinate width, derived arithmetic widths, and the transaction structs.
// ----------------------------------------------------------------------------
package pcw_pkg;

  localparam int CW  = 24;                  // coordinate width
  localparam int DW  = CW + 1;              // coordinate difference width
  localparam int PW  = 2 * DW;              // signed product width
  localparam int SW  = PW + 1;              // signed sum of two products
  localparam int MW  = PW;                  // magnitude width of sums and cross term
  localparam int SLW = 23;                  // slack register width
  localparam int S2W = 2 * SLW;             // squared slack width
  localparam int EW  = (MW > S2W) ? MW : S2W; // wide multiplier operand width
  localparam int KW  = EW / 2;              // low half of a wide operand
  localparam int HW  = EW - KW;             // high half of a wide operand
  localparam int QW  = 2 * EW;              // wide product width

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t wire_a_x;
    coord_t wire_a_y;
    coord_t wire_b_x;
    coord_t wire_b_y;
    coord_t step_start_x;
    coord_t step_start_y;
    coord_t step_end_x;
    coord_t step_end_y;
  } pcw_in_t;

  typedef struct packed {
    logic hit;
    logic near_end;
    logic segments_cross;
  } pcw_out_t;

  // Classification handed from the geometry stages to the wide compare stages
  typedef struct packed {
    logic vld;
    logic case_a;   // closest wire point is A (or wire degenerate)
    logic case_b;   // closest wire point is B
    logic near_a;
    logic near_b;
    logic crosses;
  } pcw_cls_t;

endpackage
`default_nettype wire

@@ sv/pcw_geom.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcw_geom: geometry stages of the wire crossing test
// Four register stages: differences, products, sums, then classification,
// endpoint distance checks, crossing decision and cross-term magnitude.
// ----------------------------------------------------------------------------
module pcw_geom (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_vld,
  input  wire pcw_pkg::pcw_in_t         in_item,
  input  wire logic [pcw_pkg::SLW-1:0]  slack,
  output pcw_pkg::pcw_cls_t             cls,
  output logic [pcw_pkg::EW-1:0]        cr_mag,
  output logic [pcw_pkg::EW-1:0]        l2_wide,
  output logic [pcw_pkg::EW-1:0]        s2_wide
);
  import pcw_pkg::*;

  function automatic logic span(input coord_t a, input coord_t b, input coord_t p);
    return ((p >= a) && (p <= b)) || ((p >= b) && (p <= a));
  endfunction

  // stage 1: differences and box flags
  logic                 v1_r;
  logic signed [DW-1:0] abx_r, aby_r, acx_r, acy_r, apx_r, apy_r, bpx_r, bpy_r;
  logic signed [DW-1:0] cdx_r, cdy_r, cbx_r, cby_r;
  logic                 nz1_r, bc1_r, bd1_r, ba1_r, bb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    abx_r <= DW'(in_item.wire_b_x) - DW'(in_item.wire_a_x);
    aby_r <= DW'(in_item.wire_b_y) - DW'(in_item.wire_a_y);
    acx_r <= DW'(in_item.step_start_x) - DW'(in_item.wire_a_x);
    acy_r <= DW'(in_item.step_start_y) - DW'(in_item.wire_a_y);
    apx_r <= DW'(in_item.step_end_x) - DW'(in_item.wire_a_x);
    apy_r <= DW'(in_item.step_end_y) - DW'(in_item.wire_a_y);
    bpx_r <= DW'(in_item.step_end_x) - DW'(in_item.wire_b_x);
    bpy_r <= DW'(in_item.step_end_y) - DW'(in_item.wire_b_y);
    cdx_r <= DW'(in_item.step_end_x) - DW'(in_item.step_start_x);
    cdy_r <= DW'(in_item.step_end_y) - DW'(in_item.step_start_y);
    cbx_r <= DW'(in_item.wire_b_x) - DW'(in_item.step_start_x);
    cby_r <= DW'(in_item.wire_b_y) - DW'(in_item.step_start_y);
    nz1_r <= (in_item.step_start_x != in_item.step_end_x) ||
             (in_item.step_start_y != in_item.step_end_y);
    bc1_r <= span(in_item.wire_a_x, in_item.wire_b_x, in_item.step_start_x) &&
             span(in_item.wire_a_y, in_item.wire_b_y, in_item.step_start_y);
    bd1_r <= span(in_item.wire_a_x, in_item.wire_b_x, in_item.step_end_x) &&
             span(in_item.wire_a_y, in_item.wire_b_y, in_item.step_end_y);
    ba1_r <= span(in_item.step_start_x, in_item.step_end_x, in_item.wire_a_x) &&
             span(in_item.step_start_y, in_item.step_end_y, in_item.wire_a_y);
    bb1_r <= span(in_item.step_start_x, in_item.step_end_x, in_item.wire_b_x) &&
             span(in_item.step_start_y, in_item.step_end_y, in_item.wire_b_y);
  end

  // stage 2: products
  logic                 v2_r;
  logic signed [PW-1:0] abx2_r, aby2_r, dotx_r, doty_r, apx2_r, apy2_r, bpx2_r, bpy2_r;
  logic signed [PW-1:0] o1a_r, o1b_r, cra_r, crb_r, o3a_r, o3b_r, o4a_r, o4b_r;
  logic [S2W-1:0]       s2_2_r;
  logic                 nz2_r, bc2_r, bd2_r, ba2_r, bb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    abx2_r <= abx_r * abx_r;
    aby2_r <= aby_r * aby_r;
    dotx_r <= apx_r * abx_r;
    doty_r <= apy_r * aby_r;
    apx2_r <= apx_r * apx_r;
    apy2_r <= apy_r * apy_r;
    bpx2_r <= bpx_r * bpx_r;
    bpy2_r <= bpy_r * bpy_r;
    o1a_r  <= abx_r * acy_r;
    o1b_r  <= aby_r * acx_r;
    cra_r  <= abx_r * apy_r;
    crb_r  <= aby_r * apx_r;
    o3a_r  <= cdx_r * acy_r;
    o3b_r  <= cdy_r * acx_r;
    o4a_r  <= cdx_r * cby_r;
    o4b_r  <= cdy_r * cbx_r;
    s2_2_r <= S2W'(slack) * S2W'(slack);
    nz2_r  <= nz1_r;
    bc2_r  <= bc1_r;
    bd2_r  <= bd1_r;
    ba2_r  <= ba1_r;
    bb2_r  <= bb1_r;
  end

  // stage 3: sums
  logic                 v3_r;
  logic [MW-1:0]        l2_r, da2_r, db2_r;
  logic signed [SW-1:0] dot_r, cr_r, o1_r, o3n_r, o4_r;
  logic [S2W-1:0]       s2_3_r;
  logic                 nz3_r, bc3_r, bd3_r, ba3_r, bb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    l2_r   <= MW'(abx2_r) + MW'(aby2_r);
    da2_r  <= MW'(apx2_r) + MW'(apy2_r);
    db2_r  <= MW'(bpx2_r) + MW'(bpy2_r);
    dot_r  <= SW'(dotx_r) + SW'(doty_r);
    cr_r   <= SW'(cra_r) - SW'(crb_r);
    o1_r   <= SW'(o1a_r) - SW'(o1b_r);
    o3n_r  <= SW'(o3a_r) - SW'(o3b_r);
    o4_r   <= SW'(o4a_r) - SW'(o4b_r);
    s2_3_r <= s2_2_r;
    nz3_r  <= nz2_r;
    bc3_r  <= bc2_r;
    bd3_r  <= bd2_r;
    ba3_r  <= ba2_r;
    bb3_r  <= bb2_r;
  end

  // stage 4: classification and crossing decision
  logic                 z1, z2, z3, z4, p1, p2, p3, p4;
  logic signed [SW-1:0] cr_abs;
  pcw_cls_t             cls_nxt;
  pcw_cls_t             cls_r;
  logic [EW-1:0]        cr_mag_r, l2_wide_r, s2_wide_r;

  always_comb begin
    z1 = (o1_r == '0);
    z2 = (cr_r == '0);
    z3 = (o3n_r == '0);
    z4 = (o4_r == '0);
    p1 = !o1_r[SW-1] && !z1;
    p2 = !cr_r[SW-1] && !z2;
    p3 = o3n_r[SW-1];            // orientation of A about the step is the negation
    p4 = !o4_r[SW-1] && !z4;
    cr_abs = cr_r[SW-1] ? -cr_r : cr_r;
    cls_nxt.vld     = v3_r;
    cls_nxt.case_a  = (l2_r == '0) || dot_r[SW-1] || (dot_r == '0);
    cls_nxt.case_b  = dot_r >= $signed({1'b0, l2_r});
    cls_nxt.near_a  = EW'(da2_r) <= EW'(s2_3_r);
    cls_nxt.near_b  = EW'(db2_r) <= EW'(s2_3_r);
    cls_nxt.crosses = nz3_r &&
                      ((!z1 && !z2 && !z3 && !z4 && (p1 != p2) && (p3 != p4)) ||
                       (z1 && bc3_r) || (z2 && bd3_r) || (z3 && ba3_r) || (z4 && bb3_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r <= '0;
    end else begin
      cls_r <= cls_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cr_mag_r  <= EW'(cr_abs[MW-1:0]);
    l2_wide_r <= EW'(l2_r);
    s2_wide_r <= EW'(s2_3_r);
  end

  assign cls     = cls_r;
  assign cr_mag  = cr_mag_r;
  assign l2_wide = l2_wide_r;
  assign s2_wide = s2_wide_r;

endmodule
`default_nettype wire

@@ sv/pcw_wcmp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcw_wcmp: wide product compare and result stage
// Compares the squared cross term with squared slack times squared wire
// length using split partial products, then selects the end-point distance
// outcome and forms the result.
// ----------------------------------------------------------------------------
module pcw_wcmp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pcw_pkg::pcw_cls_t    cls,
  input  wire logic [pcw_pkg::EW-1:0] cr_mag,
  input  wire logic [pcw_pkg::EW-1:0] l2_wide,
  input  wire logic [pcw_pkg::EW-1:0] s2_wide,
  output logic                      res_vld,
  output pcw_pkg::pcw_out_t         res
);
  import pcw_pkg::*;

  // stage 5: partial products
  pcw_cls_t          cls5_r;
  logic [2*HW-1:0]   c_hh_r, m_hh_r;
  logic [EW-1:0]     c_hl_r, m_hl_r, m_lh_r;
  logic [2*KW-1:0]   c_ll_r, m_ll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls5_r <= '0;
    end else begin
      cls5_r <= cls;
    end
  end

  always_ff @(posedge clk) begin
    c_hh_r <= (2*HW)'(cr_mag[EW-1:KW]) * (2*HW)'(cr_mag[EW-1:KW]);
    c_hl_r <= EW'(cr_mag[EW-1:KW]) * EW'(cr_mag[KW-1:0]);
    c_ll_r <= (2*KW)'(cr_mag[KW-1:0]) * (2*KW)'(cr_mag[KW-1:0]);
    m_hh_r <= (2*HW)'(s2_wide[EW-1:KW]) * (2*HW)'(l2_wide[EW-1:KW]);
    m_hl_r <= EW'(s2_wide[EW-1:KW]) * EW'(l2_wide[KW-1:0]);
    m_lh_r <= EW'(s2_wide[KW-1:0]) * EW'(l2_wide[EW-1:KW]);
    m_ll_r <= (2*KW)'(s2_wide[KW-1:0]) * (2*KW)'(l2_wide[KW-1:0]);
  end

  // stage 6: merge partial products
  pcw_cls_t      cls6_r;
  logic [QW-1:0] cq_r, mq_r;
  logic [EW:0]   m_mid;

  assign m_mid = {1'b0, m_hl_r} + {1'b0, m_lh_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls6_r <= '0;
    end else begin
      cls6_r <= cls5_r;
    end
  end

  always_ff @(posedge clk) begin
    cq_r <= {c_hh_r, c_ll_r} + (QW'(c_hl_r) << (KW + 1));
    mq_r <= {m_hh_r, m_ll_r} + (QW'(m_mid) << KW);
  end

  // stage 7: select and register the result
  logic     near_c, near_nxt;
  logic     res_vld_r;
  pcw_out_t res_r;

  always_comb begin
    near_c = cq_r <= mq_r;
    priority if (cls6_r.case_a) begin
      near_nxt = cls6_r.near_a;
    end else if (cls6_r.case_b) begin
      near_nxt = cls6_r.near_b;
    end else begin
      near_nxt = near_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= cls6_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r.hit            <= near_nxt || cls6_r.crosses;
    res_r.near_end       <= near_nxt;
    res_r.segments_cross <= cls6_r.crosses;
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule
`default_nettype wire

@@ sv/path_crosses_wire_2d.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// path_crosses_wire_2d: step versus wire touch and crossing test
// A fully pipelined block that takes one transaction per clock and returns
// one result per transaction. busy never rises, so a start is taken in every
// cycle. Each result appears on out_result with out_valid high for one cycle;
// results leave in the order taken and the receiver must capture every
// one. The seven register stages are: differences, 25x25 products, sums,
// classification, split partial products of the wide cross-term and
// slack-length products, their merge, and the final compare. Write
// cfg_slack only while no transaction is in flight; cfg_ready is always
// high.
// ----------------------------------------------------------------------------
module path_crosses_wire_2d (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire pcw_pkg::pcw_in_t         in_item,
  output logic                          out_valid,
  output pcw_pkg::pcw_out_t             out_result,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [pcw_pkg::SLW-1:0]  cfg_slack
);
  import pcw_pkg::*;

  logic [SLW-1:0] slack_r;
  logic           in_go;
  pcw_cls_t       cls;
  logic [EW-1:0]  cr_mag, l2_wide, s2_wide;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_go     = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slack_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      slack_r <= cfg_slack;
    end
  end

  pcw_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_go),
    .in_item (in_item),
    .slack   (slack_r),
    .cls     (cls),
    .cr_mag  (cr_mag),
    .l2_wide (l2_wide),
    .s2_wide (s2_wide)
  );

  pcw_wcmp u_wcmp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cls     (cls),
    .cr_mag  (cr_mag),
    .l2_wide (l2_wide),
    .s2_wide (s2_wide),
    .res_vld (out_valid),
    .res     (out_result)
  );

endmodule
`default_nettype wire
